// File: rtl/shmc_pkg.sv
// shmc_pkg: shared constants, codes and digit helpers for the settable clock
// used by settable_hour_minute_clock_core and shmc_checker; no dependencies
package shmc_pkg;

  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int LED_W    = 2;
  localparam int SW_W     = 4;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
  localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;

  // request kinds
  localparam logic REQ_PRESS = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // switch bit positions
  localparam int SW_MODE   = 0;
  localparam int SW_RESET  = 1;
  localparam int SW_HOUR   = 2;
  localparam int SW_MINUTE = 3;

  // led codes
  localparam logic [LED_W-1:0] LED_NORMAL  = 2'd0;
  localparam logic [LED_W-1:0] LED_BLINK_A = 2'd1;
  localparam logic [LED_W-1:0] LED_BLINK_B = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_HOUR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_MINUTE = 1'b1;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
  } digits_t;

  // hours are always 0..23, minutes 0..59
  function automatic digits_t to_digits(logic [HOUR_W-1:0] h, logic [MINUTE_W-1:0] m);
    digits_t d;
    logic [HOUR_W-1:0]   h_rem;
    logic [MINUTE_W-1:0] m_rem;
    if (h >= 5'd20) begin
      d.hour_tens = 2'd2;
      h_rem = h - 5'd20;
    end else if (h >= 5'd10) begin
      d.hour_tens = 2'd1;
      h_rem = h - 5'd10;
    end else begin
      d.hour_tens = 2'd0;
      h_rem = h;
    end
    if (m >= 6'd50) begin
      d.minute_tens = 3'd5;
      m_rem = m - 6'd50;
    end else if (m >= 6'd40) begin
      d.minute_tens = 3'd4;
      m_rem = m - 6'd40;
    end else if (m >= 6'd30) begin
      d.minute_tens = 3'd3;
      m_rem = m - 6'd30;
    end else if (m >= 6'd20) begin
      d.minute_tens = 3'd2;
      m_rem = m - 6'd20;
    end else if (m >= 6'd10) begin
      d.minute_tens = 3'd1;
      m_rem = m - 6'd10;
    end else begin
      d.minute_tens = 3'd0;
      m_rem = m;
    end
    d.hour_ones   = h_rem[3:0];
    d.minute_ones = m_rem[3:0];
    return d;
  endfunction

endpackage

// File: rtl/settable_hour_minute_clock_core.sv
// settable_hour_minute_clock_core: 24-hour clock with set mode, driven by tick and switch beats
// depends on shmc_pkg
// a result beat is registered and shows in the cycle after its input beat is accepted
// throughput: one beat per cycle; the single output register is refilled in the
//   cycle it is taken, so input stalls only while an unread result is held
// reset (rst_n low, synchronous): time 00:00:00, set mode off, led normal,
//   both reset-time registers zero, output empty
module settable_hour_minute_clock_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [3:0] in_switches,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_hour_tens,
  output logic [3:0] out_hour_ones,
  output logic [2:0] out_minute_tens,
  output logic [3:0] out_minute_ones,
  output logic [1:0] out_led_pattern,
  output logic       out_setting_mode
);

  logic [shmc_pkg::HOUR_W-1:0]   reset_hour_r;
  logic [shmc_pkg::MINUTE_W-1:0] reset_minute_r;

  logic [shmc_pkg::HOUR_W-1:0]   hours_r, hours_nxt;
  logic [shmc_pkg::MINUTE_W-1:0] minutes_r, minutes_nxt;
  logic [shmc_pkg::SECOND_W-1:0] seconds_r, seconds_nxt;
  logic                          set_mode_r, set_mode_nxt;
  logic [shmc_pkg::LED_W-1:0]    led_r, led_nxt;

  logic                      out_valid_r;
  shmc_pkg::digits_t         digits_r, digits_nxt;

  logic                          in_accept;
  logic [shmc_pkg::HOUR_W-1:0]   hour_step;
  logic [shmc_pkg::MINUTE_W-1:0] minute_inc;
  logic                          minute_wrap;
  logic [shmc_pkg::HOUR_W-1:0]   hour_after_min;
  logic [shmc_pkg::HOUR_W-1:0]   hour_load;
  logic [shmc_pkg::MINUTE_W-1:0] minute_load;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // plain increments with wrap
  assign hour_step      = (hours_r >= shmc_pkg::HOUR_MAX) ? '0 : hours_r + 1'b1;
  assign minute_wrap    = (minutes_r >= shmc_pkg::MINUTE_MAX);
  assign minute_inc     = minute_wrap ? '0 : minutes_r + 1'b1;
  assign hour_after_min = minute_wrap ? hour_step : hours_r;

  // out-of-range reset values saturate
  assign hour_load   = (reset_hour_r > shmc_pkg::HOUR_MAX) ? shmc_pkg::HOUR_MAX : reset_hour_r;
  assign minute_load = (reset_minute_r > shmc_pkg::MINUTE_MAX) ?
                       shmc_pkg::MINUTE_MAX : reset_minute_r;

  always_comb begin
    hours_nxt    = hours_r;
    minutes_nxt  = minutes_r;
    seconds_nxt  = seconds_r;
    set_mode_nxt = set_mode_r;
    led_nxt      = led_r;
    if (in_req_type == shmc_pkg::REQ_TICK) begin
      if (!set_mode_r) begin
        if (seconds_r >= shmc_pkg::SECOND_MAX) begin
          seconds_nxt = '0;
          minutes_nxt = minute_inc;
          hours_nxt   = hour_after_min;
        end else begin
          seconds_nxt = seconds_r + 1'b1;
        end
      end else begin
        led_nxt = (led_r == shmc_pkg::LED_BLINK_A) ? shmc_pkg::LED_BLINK_B :
                  shmc_pkg::LED_BLINK_A;
      end
    end else begin
      // highest switch bit wins
      if (in_switches[shmc_pkg::SW_MINUTE]) begin
        if (set_mode_r) begin
          minutes_nxt = minute_inc;
          hours_nxt   = hour_after_min;
        end
      end else if (in_switches[shmc_pkg::SW_HOUR]) begin
        if (set_mode_r) begin
          hours_nxt = hour_step;
        end
      end else if (in_switches[shmc_pkg::SW_RESET]) begin
        hours_nxt   = hour_load;
        minutes_nxt = minute_load;
      end else if (in_switches[shmc_pkg::SW_MODE]) begin
        set_mode_nxt = !set_mode_r;
        if (set_mode_r) begin
          led_nxt = shmc_pkg::LED_NORMAL;
        end
      end
    end
  end

  assign digits_nxt = shmc_pkg::to_digits(hours_nxt, minutes_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_hour_r   <= '0;
      reset_minute_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        shmc_pkg::CFG_RESET_HOUR:   reset_hour_r   <= cfg_data[shmc_pkg::HOUR_W-1:0];
        shmc_pkg::CFG_RESET_MINUTE: reset_minute_r <= cfg_data[shmc_pkg::MINUTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hours_r     <= '0;
      minutes_r   <= '0;
      seconds_r   <= '0;
      set_mode_r  <= 1'b0;
      led_r       <= shmc_pkg::LED_NORMAL;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        hours_r    <= hours_nxt;
        minutes_r  <= minutes_nxt;
        seconds_r  <= seconds_nxt;
        set_mode_r <= set_mode_nxt;
        led_r      <= led_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (in_accept) begin
      digits_r <= digits_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hour_tens    = digits_r.hour_tens;
  assign out_hour_ones    = digits_r.hour_ones;
  assign out_minute_tens  = digits_r.minute_tens;
  assign out_minute_ones  = digits_r.minute_ones;
  assign out_led_pattern  = led_r;
  assign out_setting_mode = set_mode_r;

endmodule

// File: rtl/shmc_checker.sv
// shmc_checker: port-level assertions for settable_hour_minute_clock_core, bound to it below
// depends on shmc_pkg
module shmc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_hour_tens,
  input logic [3:0] out_hour_ones,
  input logic [2:0] out_minute_tens,
  input logic [3:0] out_minute_ones,
  input logic [1:0] out_led_pattern,
  input logic       out_setting_mode
);

  // output empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  // every accepted beat shows up next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hour_tens) &&
    $stable(out_hour_ones) && $stable(out_minute_tens) && $stable(out_minute_ones) &&
    $stable(out_led_pattern) && $stable(out_setting_mode))
    else $error("stalled result beat changed");

  // displayed time stays a legal 24-hour time
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hour_tens != 2'd3 && out_hour_ones <= 4'd9 &&
    !(out_hour_tens == 2'd2 && out_hour_ones > 4'd3) &&
    out_minute_tens <= 3'd5 && out_minute_ones <= 4'd9)
    else $error("displayed time out of range");

  // blinking only in set mode
  a_led_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_setting_mode |-> out_led_pattern == shmc_pkg::LED_NORMAL)
    else $error("led blinking outside set mode");

endmodule

bind settable_hour_minute_clock_core shmc_checker u_shmc_checker (.*);

// File: dv/tb_settable_hour_minute_clock_core.sv
`timescale 1ns / 100ps
// tb_settable_hour_minute_clock_core: self-checking bench for the settable 24-hour clock,
// with a scoreboard class that predicts each displayed time and led state per beat
// depends on shmc_pkg and settable_hour_minute_clock_core
module tb_settable_hour_minute_clock_core;
  import shmc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 145;

  typedef struct {
    digits_t          digits;
    logic [LED_W-1:0] led;
    logic             setting;
  } clock_face_t;

  class clock_face_scoreboard;
    logic [HOUR_W-1:0]   hours;
    logic [MINUTE_W-1:0] minutes;
    logic [SECOND_W-1:0] seconds;
    logic                set_mode;
    logic [LED_W-1:0]    led;
    logic [HOUR_W-1:0]   preset_hour;
    logic [MINUTE_W-1:0] preset_minute;
    clock_face_t         expected_faces[$];
    int                  errors;
    int                  beats_seen;

    function new();
      hours = '0;
      minutes = '0;
      seconds = '0;
      set_mode = 1'b0;
      led = LED_NORMAL;
      preset_hour = '0;
      preset_minute = '0;
      errors = 0;
      beats_seen = 0;
    endfunction

    function int pending();
      return expected_faces.size();
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_RESET_HOUR) preset_hour = data[HOUR_W-1:0];
      else preset_minute = data[MINUTE_W-1:0];
    endfunction

    function void advance_hour();
      hours = (hours >= HOUR_MAX) ? '0 : hours + 1'b1;
    endfunction

    function void advance_minute();
      if (minutes >= MINUTE_MAX) begin
        minutes = '0;
        advance_hour();
      end else begin
        minutes = minutes + 1'b1;
      end
    endfunction

    // applies one accepted input beat and queues the face it should produce
    function void note_beat(logic req, logic [SW_W-1:0] sw);
      clock_face_t face;
      if (req == REQ_TICK) begin
        if (!set_mode) begin
          if (seconds >= SECOND_MAX) begin
            seconds = '0;
            advance_minute();
          end else begin
            seconds = seconds + 1'b1;
          end
        end else begin
          led = (led == LED_BLINK_A) ? LED_BLINK_B : LED_BLINK_A;
        end
      end else if (sw[SW_MINUTE]) begin
        if (set_mode) advance_minute();
      end else if (sw[SW_HOUR]) begin
        if (set_mode) advance_hour();
      end else if (sw[SW_RESET]) begin
        hours = (preset_hour > HOUR_MAX) ? HOUR_MAX : preset_hour;
        minutes = (preset_minute > MINUTE_MAX) ? MINUTE_MAX : preset_minute;
      end else if (sw[SW_MODE]) begin
        set_mode = !set_mode;
        if (!set_mode) led = LED_NORMAL;
      end
      face.digits.hour_tens   = 2'(hours / 10);
      face.digits.hour_ones   = 4'(hours % 10);
      face.digits.minute_tens = 3'(minutes / 10);
      face.digits.minute_ones = 4'(minutes % 10);
      face.led     = led;
      face.setting = set_mode;
      expected_faces.push_back(face);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("ERROR: result beat %0d: %s", beats_seen, msg);
    endtask

    task compare_field(string what, int got, int want);
      if (got != want) report_mismatch($sformatf("%s got %0d, want %0d", what, got, want));
    endtask

    task check_result(digits_t got, logic [LED_W-1:0] got_led, logic got_setting);
      clock_face_t want;
      beats_seen++;
      if (expected_faces.size() == 0) begin
        report_mismatch("result with no expectation waiting");
      end else begin
        want = expected_faces.pop_front();
        compare_field("hour_tens", int'(got.hour_tens), int'(want.digits.hour_tens));
        compare_field("hour_ones", int'(got.hour_ones), int'(want.digits.hour_ones));
        compare_field("minute_tens", int'(got.minute_tens), int'(want.digits.minute_tens));
        compare_field("minute_ones", int'(got.minute_ones), int'(want.digits.minute_ones));
        compare_field("led_pattern", int'(got_led), int'(want.led));
        compare_field("setting_mode", int'(got_setting), int'(want.setting));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_req_type = REQ_PRESS;
  logic [SW_W-1:0]  in_switches = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_hour_tens;
  logic [3:0]       out_hour_ones;
  logic [2:0]       out_minute_tens;
  logic [3:0]       out_minute_ones;
  logic [1:0]       out_led_pattern;
  logic             out_setting_mode;

  clock_face_scoreboard faces = new();

  int cycle_count = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_style = 0;
  int style_left = 0;

  settable_hour_minute_clock_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_switches      (in_switches),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hour_tens    (out_hour_tens),
    .out_hour_ones    (out_hour_ones),
    .out_minute_tens  (out_minute_tens),
    .out_minute_ones  (out_minute_ones),
    .out_led_pattern  (out_led_pattern),
    .out_setting_mode (out_setting_mode)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: long hold-offs on request, otherwise a stall style that changes now and then
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 3);
        style_left <= $urandom_range(32, 200);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cycle_count[2];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      faces.check_result({out_hour_tens, out_hour_ones, out_minute_tens, out_minute_ones},
                         out_led_pattern, out_setting_mode);
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    faces.note_config(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_beat(logic req, logic [SW_W-1:0] sw);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_switches <= sw;
    do @(posedge clk); while (in_stall);
    faces.note_beat(req, sw);
    if (burst_left > 0) begin
      burst_left--;
    end else if (!no_gaps) begin
      burst_left = $urandom_range(1, 20);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (faces.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic send_random_beat(bit run_heavy);
    logic [SW_W-1:0] sw;
    int pick;
    sw = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < (run_heavy ? 85 : 45)) begin
      send_beat(REQ_TICK, sw);
    end else begin
      pick = $urandom_range(0, 99);
      // weight toward single actions; lower bits are random under the winning bit
      if (pick < 15) sw = 4'b0001;
      else if (pick < 25) sw = {3'b001, sw[0]};
      else if (pick < 55) sw = {2'b01, sw[1:0]};
      else if (pick < 85) sw = {1'b1, sw[2:0]};
      else sw = 4'b0000;
      send_beat(REQ_PRESS, sw);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // out-of-range presets saturate to 23:59
    write_cfg(CFG_RESET_HOUR, 6'h3F);
    write_cfg(CFG_RESET_MINUTE, 6'h3F);

    send_beat(REQ_PRESS, 4'b0000);
    send_beat(REQ_TICK, 4'b1111);
    send_beat(REQ_PRESS, 4'b1000);
    send_beat(REQ_PRESS, 4'b0100);
    send_beat(REQ_PRESS, 4'b0010);
    send_beat(REQ_PRESS, 4'b0001);
    send_beat(REQ_TICK, 4'b0000);
    send_beat(REQ_TICK, 4'b0101);
    send_beat(REQ_TICK, 4'b1010);
    send_beat(REQ_PRESS, 4'b1000);
    send_beat(REQ_PRESS, 4'b0100);
    send_beat(REQ_PRESS, 4'b0110);
    send_beat(REQ_PRESS, 4'b0011);
    send_beat(REQ_PRESS, 4'b0100);
    send_beat(REQ_PRESS, 4'b1111);
    send_beat(REQ_PRESS, 4'b0000);
    send_beat(REQ_PRESS, 4'b0010);
    send_beat(REQ_PRESS, 4'b0001);
    send_beat(REQ_TICK, 4'b0000);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          write_cfg(CFG_RESET_HOUR, 6'd23);
          write_cfg(CFG_RESET_MINUTE, 6'd59);
        end
        1: begin
          write_cfg(CFG_RESET_HOUR, 6'd0);
          write_cfg(CFG_RESET_MINUTE, 6'd0);
        end
        2: begin
          write_cfg(CFG_RESET_HOUR, 6'h3F);
          write_cfg(CFG_RESET_MINUTE, 6'd60);
        end
        default: begin
          write_cfg(CFG_RESET_HOUR, 6'($urandom_range(0, 63)));
          write_cfg(CFG_RESET_MINUTE, 6'($urandom_range(0, 63)));
        end
      endcase
      no_gaps = (p == 3 || p == 4 || p == 7);
      burst_left = 0;
      if (p == 4) holds_asked++;
      send_beat(REQ_PRESS, {3'b001, 1'($urandom_range(0, 1))});
      for (int i = 1; i < PHASE_BEATS; i++) send_random_beat(p % 2 == 0);
    end

    settle();
    if (faces.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/shmc_pkg.sv
rtl/settable_hour_minute_clock_core.sv
rtl/shmc_checker.sv
dv/tb_settable_hour_minute_clock_core.sv
